// ===== rtl/core/indexed_list_store_assert.svh =====
// Assertion macros used by the list store RTL.
// Each check is clocked by clock and held off while reset is high.
`ifndef INDEXED_LIST_STORE_ASSERT_SVH
`define INDEXED_LIST_STORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define ILS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define ILS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define ILS_ASSERT_NOW(lbl, ante, cons, msg)
`define ILS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/core/ils_pkg.sv =====
package ils_pkg;

   localparam int CAPACITY_DEF   = 256;
   localparam int ITEM_WIDTH_DEF = 32;

   localparam int ACTION_W = 3;
   localparam int INDEX_W  = 8;
   localparam int ITEM_W   = 32;
   localparam int STATUS_W = 2;
   localparam int FILL_W   = 9;

   typedef enum logic [ACTION_W-1:0] {
      ACT_PUSH   = 3'd0,
      ACT_POP    = 3'd1,
      ACT_GET    = 3'd2,
      ACT_SET    = 3'd3,
      ACT_REMOVE = 3'd4,
      ACT_CLEAR  = 3'd5
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

endpackage

// ===== rtl/core/ils_ram.sv =====
module ils_ram #(
   parameter int WIDTH = ils_pkg::ITEM_WIDTH_DEF,
   parameter int DEPTH = ils_pkg::CAPACITY_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/indexed_list_store.sv =====
// Push, set, clear and any rejected request: strobe registered from the decode state.
// Pop and get add a wait state for the registered read of the entry RAM.
// Remove at index i reads that entry, then moves each later entry down one place; the
// entry RAM moves one entry per cycle through its single write port.
// A new request is taken in the cycle the strobe is high; the receiver cannot stall.
// Reset clears the fill count at once; the entry RAM is not cleared and needs no sweep.
`include "indexed_list_store_assert.svh"

module indexed_list_store #(
   parameter int CAPACITY   = ils_pkg::CAPACITY_DEF,
   parameter int ITEM_WIDTH = ils_pkg::ITEM_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [ils_pkg::ACTION_W-1:0]  req_action,
   input  logic [ils_pkg::INDEX_W-1:0]   req_index,
   input  logic [ils_pkg::ITEM_W-1:0]    req_item_in,
   output logic                          rsp_strobe,
   output logic [ils_pkg::STATUS_W-1:0]  rsp_status,
   output logic [ils_pkg::ITEM_W-1:0]    rsp_item_out,
   output logic [ils_pkg::FILL_W-1:0]    rsp_fill_count
);

   import ils_pkg::*;

   localparam int AW    = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
   localparam int XW    = (ITEM_WIDTH > ITEM_W) ? ITEM_WIDTH : ITEM_W;
   localparam int FW    = (CNT_W > FILL_W) ? CNT_W : FILL_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_RD_WAIT,
      S_RM_HEAD,
      S_RM_SHIFT
   } state_type;

   state_type               state_ff, state_in;
   action_type              act_ff, act_in;
   logic [INDEX_W-1:0]      idx_ff, idx_in;
   logic [ITEM_W-1:0]       data_ff, data_in;
   logic [ITEM_W-1:0]       res_ff, res_in;
   logic [CNT_W-1:0]        ptr_ff, ptr_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic [ITEM_W-1:0]       rsp_item_ff, rsp_item_in;
   logic [FILL_W-1:0]       rsp_fill_ff, rsp_fill_in;

   logic                    mem_we;
   logic [AW-1:0]           mem_waddr;
   logic [ITEM_WIDTH-1:0]   mem_wdata;
   logic                    mem_re;
   logic [AW-1:0]           mem_raddr;
   logic [ITEM_WIDTH-1:0]   mem_rdata;

   logic [XW-1:0]           data_ext;
   logic [XW-1:0]           rd_ext;
   logic [ITEM_W-1:0]       rd_item;
   logic [CMP_W-1:0]        idx_ext;
   logic [CMP_W-1:0]        count_ext;
   logic                    idx_bad;
   logic [CNT_W-1:0]        count_m1;
   logic [CNT_W-1:0]        ptr_p1;
   logic [CNT_W-1:0]        ptr_p2;
   logic [FW-1:0]           fill_ext;

   assign data_ext  = XW'(data_ff);
   assign rd_ext    = XW'(mem_rdata);
   assign rd_item   = rd_ext[ITEM_W-1:0];
   assign idx_ext   = CMP_W'(idx_ff);
   assign count_ext = CMP_W'(count_ff);
   assign idx_bad   = (idx_ext >= count_ext);
   assign count_m1  = count_ff - CNT_W'(1);
   assign ptr_p1    = ptr_ff + CNT_W'(1);
   assign ptr_p2    = ptr_ff + CNT_W'(2);
   assign fill_ext  = FW'(count_in);

   always_comb begin
      state_in      = state_ff;
      act_in        = act_ff;
      idx_in        = idx_ff;
      data_in       = data_ff;
      res_in        = res_ff;
      ptr_in        = ptr_ff;
      count_in      = count_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_item_in   = rsp_item_ff;
      rsp_fill_in   = rsp_fill_ff;
      mem_we        = 1'b0;
      mem_waddr     = count_ff[AW-1:0];
      mem_wdata     = data_ext[ITEM_WIDTH-1:0];
      mem_re        = 1'b0;
      mem_raddr     = idx_ext[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               act_in   = action_type'(req_action);
               idx_in   = req_index;
               data_in  = req_item_in;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            // Requests that finish here answer with a zero item.
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_OK;
            rsp_item_in   = '0;
            state_in      = S_IDLE;
            case (act_ff)
               ACT_PUSH: begin
                  if (count_ff == CNT_W'(CAPACITY)) begin
                     rsp_status_in = ST_FULL;
                  end else begin
                     mem_we   = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                  end
               end
               ACT_POP: begin
                  if (count_ff == '0) begin
                     rsp_status_in = ST_RANGE;
                  end else begin
                     count_in     = count_m1;
                     mem_re       = 1'b1;
                     mem_raddr    = count_m1[AW-1:0];
                     rsp_valid_in = 1'b0;
                     state_in     = S_RD_WAIT;
                  end
               end
               ACT_GET: begin
                  if (idx_bad) begin
                     rsp_status_in = ST_RANGE;
                  end else begin
                     mem_re       = 1'b1;
                     rsp_valid_in = 1'b0;
                     state_in     = S_RD_WAIT;
                  end
               end
               ACT_SET: begin
                  if (idx_bad) begin
                     rsp_status_in = ST_RANGE;
                  end else begin
                     mem_we    = 1'b1;
                     mem_waddr = idx_ext[AW-1:0];
                  end
               end
               ACT_REMOVE: begin
                  if (idx_bad) begin
                     rsp_status_in = ST_RANGE;
                  end else begin
                     mem_re       = 1'b1;
                     ptr_in       = idx_ext[CNT_W-1:0];
                     rsp_valid_in = 1'b0;
                     state_in     = S_RM_HEAD;
                  end
               end
               ACT_CLEAR: begin
                  count_in = '0;
               end
               default: begin
                  rsp_status_in = ST_RANGE;
               end
            endcase
         end
         S_RD_WAIT: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_OK;
            rsp_item_in   = rd_item;
            state_in      = S_IDLE;
         end
         S_RM_HEAD: begin
            res_in = rd_item;
            if (ptr_ff < count_m1) begin
               mem_re    = 1'b1;
               mem_raddr = ptr_p1[AW-1:0];
               state_in  = S_RM_SHIFT;
            end else begin
               count_in      = count_m1;
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_item_in   = rd_item;
               state_in      = S_IDLE;
            end
         end
         S_RM_SHIFT: begin
            // The entry one place up arrives now and drops into the current slot,
            // while the read of the next one is already under way.
            mem_we    = 1'b1;
            mem_waddr = ptr_ff[AW-1:0];
            mem_wdata = mem_rdata;
            ptr_in    = ptr_p1;
            if (ptr_p1 < count_m1) begin
               mem_re    = 1'b1;
               mem_raddr = ptr_p2[AW-1:0];
            end else begin
               count_in      = count_m1;
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_item_in   = res_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (rsp_valid_in) begin
         rsp_fill_in = fill_ext[FILL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff        <= act_in;
      idx_ff        <= idx_in;
      data_ff       <= data_in;
      res_ff        <= res_in;
      ptr_ff        <= ptr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_item_ff   <= rsp_item_in;
      rsp_fill_ff   <= rsp_fill_in;
   end

   ils_ram #(
      .WIDTH (ITEM_WIDTH),
      .DEPTH (CAPACITY)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign busy           = (state_ff != S_IDLE);
   assign rsp_strobe     = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_item_out   = rsp_item_ff;
   assign rsp_fill_count = rsp_fill_ff;

   `ILS_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CNT_W'(CAPACITY), "count above capacity")
   `ILS_ASSERT_NOW(a_rsp_idle, rsp_valid_ff, state_ff == S_IDLE, "result while still busy")
   `ILS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not start")
   `ILS_ASSERT_NOW(a_shift_ptr, state_ff == S_RM_SHIFT, ptr_p1 < count_ff, "shift beyond count")
   `ILS_ASSERT_NOW(a_push_count,
                   rsp_valid_ff && act_ff == ACT_PUSH && rsp_status_ff == ST_OK,
                   count_ff == $past(count_ff) + CNT_W'(1),
                   "push did not grow count")

endmodule

// ===== sim/list_store_checker.sv =====
`timescale 1ns / 1ps

module list_store_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic [ils_pkg::ACTION_W-1:0]  req_action,
   input  logic [ils_pkg::INDEX_W-1:0]   req_index,
   input  logic [ils_pkg::ITEM_W-1:0]    req_item_in,
   input  logic                          rsp_strobe,
   input  logic [ils_pkg::STATUS_W-1:0]  rsp_status,
   input  logic [ils_pkg::ITEM_W-1:0]    rsp_item_out,
   input  logic [ils_pkg::FILL_W-1:0]    rsp_fill_count,
   output int                            failures,
   output int                            pending
);

   import ils_pkg::*;

   localparam int STORE_DEPTH = CAPACITY_DEF;

   typedef struct {
      status_type        status;
      logic [ITEM_W-1:0] item;
      logic [FILL_W-1:0] fill;
   } list_reply_type;

   logic [ITEM_W-1:0] shadow_entries [0:STORE_DEPTH-1];
   int                shadow_count;
   list_reply_type    replies_due [$];

   function automatic list_reply_type predict_list_op(input logic [ACTION_W-1:0] act,
                                                      input logic [INDEX_W-1:0]  idx,
                                                      input logic [ITEM_W-1:0]   item);
      list_reply_type reply;
      int             k;
      reply.status = ST_OK;
      reply.item   = '0;
      case (act)
         ACT_PUSH: begin
            if (shadow_count >= STORE_DEPTH) begin
               reply.status = ST_FULL;
            end else begin
               shadow_entries[shadow_count] = item;
               shadow_count++;
            end
         end
         ACT_POP: begin
            if (shadow_count == 0) begin
               reply.status = ST_RANGE;
            end else begin
               shadow_count--;
               reply.item = shadow_entries[shadow_count];
            end
         end
         ACT_GET: begin
            if (int'(idx) >= shadow_count) begin
               reply.status = ST_RANGE;
            end else begin
               reply.item = shadow_entries[idx];
            end
         end
         ACT_SET: begin
            if (int'(idx) >= shadow_count) begin
               reply.status = ST_RANGE;
            end else begin
               shadow_entries[idx] = item;
            end
         end
         ACT_REMOVE: begin
            if (int'(idx) >= shadow_count) begin
               reply.status = ST_RANGE;
            end else begin
               reply.item = shadow_entries[idx];
               // Every later entry moves down one place to close the gap.
               for (k = int'(idx); k + 1 < shadow_count; k++) begin
                  shadow_entries[k] = shadow_entries[k + 1];
               end
               shadow_count--;
            end
         end
         ACT_CLEAR: begin
            shadow_count = 0;
         end
         default: begin
            reply.status = ST_RANGE;
         end
      endcase
      reply.fill = shadow_count[FILL_W-1:0];
      return reply;
   endfunction

   initial begin
      failures     = 0;
      pending      = 0;
      shadow_count = 0;
   end

   always @(posedge clock) begin
      list_reply_type want;
      if (reset) begin
         replies_due.delete();
         shadow_count = 0;
      end else begin
         // The result is checked before a request taken at the same edge is
         // queued, since that request cannot have produced it.
         if (rsp_strobe) begin
            if (replies_due.size() == 0) begin
               $display("%0t: unexpected result: expected none, actual status %0d item %h fill %0d",
                        $time, rsp_status, rsp_item_out, rsp_fill_count);
               failures++;
            end else begin
               want = replies_due.pop_front();
               if (rsp_status !== want.status) begin
                  $display("%0t: status mismatch: expected %0d, actual %0d",
                           $time, want.status, rsp_status);
                  failures++;
               end
               if (rsp_item_out !== want.item) begin
                  $display("%0t: item_out mismatch: expected %h, actual %h",
                           $time, want.item, rsp_item_out);
                  failures++;
               end
               if (rsp_fill_count !== want.fill) begin
                  $display("%0t: fill_count mismatch: expected %0d, actual %0d",
                           $time, want.fill, rsp_fill_count);
                  failures++;
               end
            end
         end
         if (start && !busy) begin
            replies_due.push_back(predict_list_op(req_action, req_index, req_item_in));
         end
      end
      pending = replies_due.size();
   end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import ils_pkg::*;

   localparam logic [ACTION_W-1:0] ACT_UNDEF_LO = 3'd6;
   localparam logic [ACTION_W-1:0] ACT_UNDEF_HI = 3'd7;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 300;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [ACTION_W-1:0] req_action;
   logic [INDEX_W-1:0]  req_index;
   logic [ITEM_W-1:0]   req_item_in;
   logic                rsp_strobe;
   logic [STATUS_W-1:0] rsp_status;
   logic [ITEM_W-1:0]   rsp_item_out;
   logic [FILL_W-1:0]   rsp_fill_count;
   int                  failures;
   int                  pending;
   int                  idle_cycles;
   int                  requests_sent;
   bit                  gapless;

   indexed_list_store i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_index      (req_index),
      .req_item_in    (req_item_in),
      .rsp_strobe     (rsp_strobe),
      .rsp_status     (rsp_status),
      .rsp_item_out   (rsp_item_out),
      .rsp_fill_count (rsp_fill_count)
   );

   list_store_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_index      (req_index),
      .req_item_in    (req_item_in),
      .rsp_strobe     (rsp_strobe),
      .rsp_status     (rsp_status),
      .rsp_item_out   (rsp_item_out),
      .rsp_fill_count (rsp_fill_count),
      .failures       (failures),
      .pending        (pending)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("** indexed_list_store: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Holds start high from a falling edge until the block takes the request.
   task automatic send_request(input logic [ACTION_W-1:0] act,
                               input logic [INDEX_W-1:0]  idx,
                               input logic [ITEM_W-1:0]   item);
      int gap;
      if (requests_sent % 32 == 0) begin
         gapless = ($urandom_range(0, 2) == 0);
      end
      gap = gapless ? 0 : $urandom_range(0, 19);
      @(negedge clock);
      if (gap != 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      start       = 1'b1;
      req_action  = act;
      req_index   = idx;
      req_item_in = item;
      do @(posedge clock); while (busy);
      requests_sent++;
   endtask

   task automatic random_request(input int push_weight);
      int                  roll;
      logic [ACTION_W-1:0] act;
      logic [INDEX_W-1:0]  idx;
      if ($urandom_range(0, 99) < push_weight) begin
         act = ACT_PUSH;
      end else begin
         roll = $urandom_range(0, 40);
         if (roll < 9)       act = ACT_POP;
         else if (roll < 19) act = ACT_GET;
         else if (roll < 29) act = ACT_SET;
         else if (roll < 39) act = ACT_REMOVE;
         else if (roll < 40) act = ACT_CLEAR;
         else                act = $urandom_range(0, 1) ? ACT_UNDEF_HI : ACT_UNDEF_LO;
      end
      // Small indices land inside the list far more often while it is short.
      idx = $urandom_range(0, 1) ? INDEX_W'($urandom_range(0, 255))
                                 : INDEX_W'($urandom_range(0, 15));
      send_request(act, idx, $urandom);
   endtask

   initial begin
      reset         = 1'b1;
      start         = 1'b0;
      req_action    = ACT_PUSH;
      req_index     = '0;
      req_item_in   = '0;
      requests_sent = 0;
      gapless       = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Empty-list requests, undefined action codes, then a short list.
      send_request(ACT_POP, 8'd0, 32'h0);
      send_request(ACT_GET, 8'd0, 32'h0);
      send_request(ACT_SET, 8'd0, 32'h1111_1111);
      send_request(ACT_REMOVE, 8'd0, 32'h0);
      send_request(ACT_UNDEF_LO, 8'd0, 32'h0);
      send_request(ACT_UNDEF_HI, 8'hFF, 32'hFFFF_FFFF);
      send_request(ACT_PUSH, 8'h00, 32'h0000_0000);
      send_request(ACT_PUSH, 8'hFF, 32'hFFFF_FFFF);
      send_request(ACT_PUSH, 8'h5A, 32'hA5A5_5A5A);
      send_request(ACT_GET, 8'd0, 32'h0);
      send_request(ACT_GET, 8'd1, 32'h0);
      send_request(ACT_GET, 8'd3, 32'h0);
      send_request(ACT_GET, 8'hFF, 32'h0);
      send_request(ACT_SET, 8'd2, 32'h1234_5678);
      send_request(ACT_SET, 8'd3, 32'h8765_4321);
      send_request(ACT_GET, 8'd2, 32'h0);
      send_request(ACT_REMOVE, 8'd0, 32'h0);
      send_request(ACT_GET, 8'd0, 32'h0);
      send_request(ACT_REMOVE, 8'd1, 32'h0);
      send_request(ACT_POP, 8'd0, 32'h0);
      send_request(ACT_PUSH, 8'd7, 32'hDEAD_BEEF);
      send_request(ACT_CLEAR, 8'hFF, 32'hFFFF_FFFF);
      send_request(ACT_GET, 8'd0, 32'h0);
      send_request(ACT_POP, 8'd0, 32'h0);

      // Mixed traffic on a short list.
      repeat (120) random_request(45);

      // Fill the list to capacity and push past it.
      send_request(ACT_CLEAR, 8'd0, 32'h0);
      repeat (258) send_request(ACT_PUSH, INDEX_W'($urandom), $urandom);
      send_request(ACT_GET, 8'hFF, 32'h0);
      // Removing the first entry of a full list shifts every other entry.
      send_request(ACT_REMOVE, 8'd0, 32'h0);
      send_request(ACT_REMOVE, 8'hFE, 32'h0);

      // Mixed traffic on a nearly full list.
      repeat (110) random_request(30);

      @(negedge clock);
      start = 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("** indexed_list_store: PASSED **");
      end else begin
         $display("** indexed_list_store: FAILED **");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/ils_pkg.sv
rtl/core/ils_ram.sv
rtl/core/indexed_list_store.sv
sim/list_store_checker.sv
sim/tb.sv
